// ===== rtl/core/ntsr_pkg.sv =====
// ntsr_pkg: shared types and codes for the name table search/remove block
// depends on nothing; imported by ntsr_cell, ntsr_pick and the top level
`default_nettype none

package ntsr_pkg;

    localparam int REQ_W    = 2;
    localparam int NAME_W   = 64;
    localparam int STATUS_W = 2;
    localparam int INDEX_W  = 4;
    localparam int HELD_W   = 5;

    typedef enum logic [REQ_W-1:0] {
        OP_INSERT = 2'd0,
        OP_FIND   = 2'd1,
        OP_REMOVE = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK      = 2'd0,
        STAT_MISSING = 2'd1,
        STAT_FULL    = 2'd2,
        STAT_UNUSED  = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CMP,
        ST_EXEC
    } state_t;

    // per-cell control from the sequencer
    typedef struct packed {
        logic cmp;    // compare held name against the broadcast key
        logic load;   // store the broadcast key
        logic shift;  // take the name of the next cell up
        logic valid;  // cell holds a name
    } cell_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/core/ntsr_cell.sv =====
// ntsr_cell: one table slot, holds a name and its registered match flag
// depends on ntsr_pkg (cell_ctl_t)
`default_nettype none

module ntsr_cell #(
    parameter int KEY_W = 64
) (
    input  wire                    aclk,
    input  wire                    aresetn,
    input  ntsr_pkg::cell_ctl_t    ctl,
    input  wire [KEY_W-1:0]        key,
    input  wire [KEY_W-1:0]        up_name,
    output logic [KEY_W-1:0]       name,
    output logic                   match
);
    import ntsr_pkg::*;

    logic [KEY_W-1:0] name_reg, name_next;
    logic             match_reg, match_next;

    always_comb begin
        name_next  = name_reg;
        match_next = match_reg;
        if (ctl.load) begin
            name_next = key;
        end else if (ctl.shift) begin
            name_next = up_name;
        end
        if (ctl.cmp) begin
            match_next = ctl.valid && (name_reg == key);
        end
    end

    always_ff @(posedge aclk) begin
        name_reg <= name_next;
        if (!aresetn) begin
            match_reg <= 1'b0;
        end else begin
            match_reg <= match_next;
        end
    end

    assign name  = name_reg;
    assign match = match_reg;

endmodule

`default_nettype wire

// ===== rtl/core/ntsr_pick.sv =====
// ntsr_pick: first-match chain over the cell match flags
// depends on ntsr_pkg
`default_nettype none

module ntsr_pick #(
    parameter int ENTRIES = 16
) (
    input  wire [ENTRIES-1:0]          match,
    output logic                       found,
    output logic [$clog2(ENTRIES)-1:0] hit_index,
    output logic [ENTRIES-1:0]         at_or_after
);
    import ntsr_pkg::*;

    localparam int IDX_W = $clog2(ENTRIES);

    logic [ENTRIES:0]   seen;
    logic [ENTRIES-1:0] first;

    // seen[i] passes from cell to cell: some earlier cell matched
    always_comb begin
        seen[0] = 1'b0;
        for (int i = 0; i < ENTRIES; i++) begin
            seen[i+1] = seen[i] | match[i];
            first[i]  = match[i] & ~seen[i];
        end
    end

    always_comb begin
        hit_index = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            if (first[i]) begin
                hit_index = hit_index | IDX_W'(i);
            end
        end
    end

    assign found       = seen[ENTRIES];
    assign at_or_after = seen[ENTRIES:1];

endmodule

`default_nettype wire

// ===== rtl/core/name_table_search_remove_top.sv =====
// name_table_search_remove_top: name table with append, first-match find and
// compacting remove, built as a row of cells; uses ntsr_pkg, ntsr_cell, ntsr_pick
//
//  channel | dir | fields (low bit up)
//  s_      | in  | s_tuser: req_type[1:0]; s_tdata: name_key[63:0]
//  m_      | out | m_tdata: status[1:0], entry_index[5:2], entries_held[10:6]
//
// one request at a time: accept, compare state, execute state; the compare
// runs in every cell at once in the compare state, and the shift of later
// cells on remove happens in the execute state.
// the result sits in an output register; the next item is accepted while it
// waits, and execute holds until the register is free.
// reset clears the fill count and control; names need no reset.
`default_nettype none

module name_table_search_remove_top #(
    parameter int TABLE_ENTRIES = 16,
    parameter int NAME_CHARS    = 8
) (
    input  wire                            aclk,
    input  wire                            aresetn,
    input  wire                            s_tvalid,
    output logic                           s_tready,
    input  wire [ntsr_pkg::NAME_W-1:0]     s_tdata,   // name_key[63:0]
    input  wire [ntsr_pkg::REQ_W-1:0]      s_tuser,   // req_type[1:0]
    output logic                           m_tvalid,
    input  wire                            m_tready,
    output logic [15:0]                    m_tdata    // status, entry_index, entries_held
);
    import ntsr_pkg::*;

    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
    localparam int KEY_W = 8 * NAME_CHARS;

    // cut at first zero byte and after NAME_CHARS bytes
    function automatic logic [KEY_W-1:0] normalize(input logic [NAME_W-1:0] raw);
        logic [NAME_W-1:0] res;
        logic              stop;
        res  = '0;
        stop = 1'b0;
        for (int b = 0; b < 8; b++) begin
            if (b >= NAME_CHARS || raw[8*b +: 8] == 8'd0) begin
                stop = 1'b1;
            end
            if (!stop) begin
                res[8*b +: 8] = raw[8*b +: 8];
            end
        end
        return res[KEY_W-1:0];
    endfunction

    state_t             state_reg, state_next;
    op_t                op_reg, op_next;
    logic [KEY_W-1:0]   key_reg, key_next;
    logic [CNT_W-1:0]   fill_reg, fill_next;
    logic               out_valid_reg, out_valid_next;
    status_t            status_reg, status_next;
    logic [IDX_W-1:0]   index_reg, index_next;
    logic [CNT_W-1:0]   held_reg, held_next;

    logic                     commit;
    logic                     full;
    cell_ctl_t                ctl   [TABLE_ENTRIES];
    logic [KEY_W-1:0]         names [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0] match;
    logic                     found;
    logic [IDX_W-1:0]         hit_index;
    logic [TABLE_ENTRIES-1:0] at_or_after;

    logic [IDX_W+INDEX_W-1:0] index_wide;
    logic [CNT_W+HELD_W-1:0]  held_wide;

    assign full = (fill_reg >= CNT_W'(TABLE_ENTRIES));

    // row of cells, each takes its upper neighbor's name on a shift
    for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
        logic [KEY_W-1:0] up_name;
        if (i == TABLE_ENTRIES - 1) begin : g_last
            assign up_name = '0;
        end else begin : g_mid
            assign up_name = names[i+1];
        end

        always_comb begin
            ctl[i].valid = (CNT_W'(i) < fill_reg);
            ctl[i].cmp   = (state_reg == ST_CMP);
            ctl[i].load  = commit && (op_reg == OP_INSERT) && (CNT_W'(i) == fill_reg);
            ctl[i].shift = commit && (op_reg == OP_REMOVE) && found && at_or_after[i]
                           && (CNT_W'(i + 1) < fill_reg);
        end

        ntsr_cell #(
            .KEY_W (KEY_W)
        ) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .ctl     (ctl[i]),
            .key     (key_reg),
            .up_name (up_name),
            .name    (names[i]),
            .match   (match[i])
        );
    end

    ntsr_pick #(
        .ENTRIES (TABLE_ENTRIES)
    ) u_pick (
        .match       (match),
        .found       (found),
        .hit_index   (hit_index),
        .at_or_after (at_or_after)
    );

    always_ff @(posedge aclk) begin
        op_reg     <= op_next;
        key_reg    <= key_next;
        status_reg <= status_next;
        index_reg  <= index_next;
        held_reg   <= held_next;
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb begin
        state_next     = state_reg;
        op_next        = op_reg;
        key_next       = key_reg;
        fill_next      = fill_reg;
        status_next    = status_reg;
        index_next     = index_reg;
        held_next      = held_reg;
        out_valid_next = out_valid_reg && !m_tready;
        s_tready       = 1'b0;
        commit         = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    op_next    = op_t'(s_tuser);
                    key_next   = normalize(s_tdata);
                    state_next = ST_CMP;
                end
            end
            ST_CMP: begin
                state_next = ST_EXEC;
            end
            ST_EXEC: begin
                if (!out_valid_reg || m_tready) begin
                    commit         = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                    status_next    = STAT_MISSING;
                    index_next     = '0;
                    unique case (op_reg)
                        OP_INSERT: begin
                            if (full) begin
                                status_next = STAT_FULL;
                            end else begin
                                status_next = STAT_OK;
                                index_next  = fill_reg[IDX_W-1:0];
                                fill_next   = fill_reg + CNT_W'(1);
                            end
                        end
                        OP_FIND: begin
                            if (found) begin
                                status_next = STAT_OK;
                                index_next  = hit_index;
                            end
                        end
                        OP_REMOVE: begin
                            if (found) begin
                                status_next = STAT_OK;
                                index_next  = hit_index;
                                fill_next   = fill_reg - CNT_W'(1);
                            end
                        end
                        default: begin
                        end
                    endcase
                    held_next = fill_next;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign index_wide = (IDX_W + INDEX_W)'(index_reg);
    assign held_wide  = (CNT_W + HELD_W)'(held_reg);

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, held_wide[HELD_W-1:0], index_wide[INDEX_W-1:0], status_reg};

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= CNT_W'(TABLE_ENTRIES))
        else $error("fill count above table size");

    a_insert_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        (commit && op_reg == OP_INSERT && !full) |=> fill_reg == $past(fill_reg) + CNT_W'(1))
        else $error("insert did not grow the table");

    a_remove_shrinks: assert property (@(posedge aclk) disable iff (!aresetn)
        (commit && op_reg == OP_REMOVE && found) |=> fill_reg == $past(fill_reg) - CNT_W'(1))
        else $error("remove did not shrink the table");

    a_match_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EXEC && found) |-> (CNT_W'(hit_index) < fill_reg))
        else $error("match outside the held entries");

endmodule

`default_nettype wire

// ===== tb/sv/tb_name_table_search_remove_top.sv =====
// tb_name_table_search_remove_top: self-checking bench for the name table block
// with append, first-match find and compacting remove, driven over its streams
// depends on ntsr_pkg and name_table_search_remove_top
`timescale 1ns / 100ps

module tb_name_table_search_remove_top;
    import ntsr_pkg::*;

    localparam int DEPTH        = 16;
    localparam int RANDOM_ITEMS = 1300;
    localparam int POOL_SIZE    = 12;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 20;
    localparam int HOLD_AT      = 400;   // results seen before the long receiver hold
    localparam int HOLD_CYCLES  = 300;
    localparam int PAUSE_AT     = 1000;  // sender waits for an empty pipe here

    typedef struct packed {
        status_t    status;
        logic [3:0] entry_index;
        logic [4:0] entries_held;
    } name_reply_t;

    class NameTableScoreboard;
        logic [63:0] names[DEPTH];
        int          held;
        name_reply_t replies[$];
        int          faults;
        int          op_count[4];
        int          full_hits;
        int          misses;
        int          peak_held;

        function new();
            held      = 0;
            faults    = 0;
            full_hits = 0;
            misses    = 0;
            peak_held = 0;
            foreach (op_count[i]) op_count[i] = 0;
        endfunction

        function int pending();
            return replies.size();
        endfunction

        // predict the reply of one accepted request and update the table copy
        function void note_request(logic [1:0] op_bits, logic [63:0] raw);
            logic [63:0] name;
            logic        ended;
            int          hit;
            name_reply_t r;
            name  = '0;
            ended = 1'b0;
            // a name ends at its first zero byte, like a string
            for (int b = 0; b < 8; b++) begin
                if (raw[8*b +: 8] == 8'h00) ended = 1'b1;
                if (!ended) name[8*b +: 8] = raw[8*b +: 8];
            end
            hit = -1;
            for (int i = 0; i < held; i++) begin
                if (hit < 0 && names[i] == name) hit = i;
            end
            r.status      = STAT_MISSING;
            r.entry_index = '0;
            op_count[op_bits]++;
            case (op_t'(op_bits))
                OP_INSERT: begin
                    if (held >= DEPTH) begin
                        r.status = STAT_FULL;
                        full_hits++;
                    end else begin
                        names[held]   = name;
                        r.entry_index = held[3:0];
                        r.status      = STAT_OK;
                        held++;
                    end
                end
                OP_FIND: begin
                    if (hit >= 0) begin
                        r.status      = STAT_OK;
                        r.entry_index = hit[3:0];
                    end else begin
                        misses++;
                    end
                end
                OP_REMOVE: begin
                    if (hit >= 0) begin
                        for (int i = hit; i + 1 < held; i++) names[i] = names[i+1];
                        held--;
                        r.status      = STAT_OK;
                        r.entry_index = hit[3:0];
                    end else begin
                        misses++;
                    end
                end
                default: ;
            endcase
            if (held > peak_held) peak_held = held;
            r.entries_held = held[4:0];
            replies.push_back(r);
        endfunction

        function void check_reply(logic [15:0] word);
            name_reply_t want;
            if (replies.size() == 0) begin
                $error("result item with no request outstanding: m_tdata %h", word);
                faults++;
                return;
            end
            want = replies.pop_front();
            if (word[1:0] !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, word[1:0]);
                faults++;
            end
            if (word[5:2] !== want.entry_index) begin
                $error("entry_index: expected %0d, got %0d", want.entry_index, word[5:2]);
                faults++;
            end
            if (word[10:6] !== want.entries_held) begin
                $error("entries_held: expected %0d, got %0d", want.entries_held, word[10:6]);
                faults++;
            end
            if (word[15:11] !== 5'b0) begin
                $error("padding: expected 0, got %h", word[15:11]);
                faults++;
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata  = '0;
    logic [1:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;

    NameTableScoreboard sb = new();
    logic [63:0]        name_pool[POOL_SIZE];
    int                 sent_count   = 0;
    int                 result_count = 0;
    int                 cycle_count  = 0;

    name_table_search_remove_top #(
        .TABLE_ENTRIES(DEPTH),
        .NAME_CHARS   (8)
    ) i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    always begin
        aclk = 1'b0;
        #2;
        aclk = 1'b1;
        #2;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // result side: check on handshake, then pick the next ready value
    initial begin
        int hold_left;
        logic held_once;
        hold_left = 0;
        held_once = 1'b0;
        forever begin
            @(posedge aclk);
            if (m_tvalid && m_tready) begin
                sb.check_reply(m_tdata);
                result_count++;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (!held_once && result_count >= HOLD_AT) begin
                held_once = 1'b1;
                hold_left = HOLD_CYCLES;
                m_tready <= 1'b0;
            end else if (result_count >= 500 && result_count < 800) begin
                m_tready <= 1'b1;
            end else begin
                m_tready <= ($urandom_range(99) >= 9);
            end
        end
    end

    // sometimes puts random bytes behind the terminating zero of a short name
    function automatic logic [63:0] dress_name(logic [63:0] name);
        logic [63:0] junk;
        int          len;
        len = 8;
        for (int b = 7; b >= 0; b--) if (name[8*b +: 8] == 8'h00) len = b;
        junk = {$urandom, $urandom};
        if (len < 7 && $urandom_range(1)) begin
            for (int b = len + 1; b < 8; b++) name[8*b +: 8] = junk[8*b +: 8];
        end
        return name;
    endfunction

    task automatic send_request(op_t op, logic [63:0] key);
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= key;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_request(op, key);
        sent_count++;
        if (!(sent_count >= 600 && sent_count < 900) && $urandom_range(99) < 9) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
    endtask

    initial begin
        int          phase;
        int          roll;
        op_t         op;
        logic [63:0] key;

        for (int p = 0; p < POOL_SIZE; p++) begin
            name_pool[p] = '0;
            for (int b = 0; b < $urandom_range(1, 8); b++)
                name_pool[p][8*b +: 8] = $urandom_range(1, 255);
        end

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: empty table, odd keys, normalization, duplicates, shift
        send_request(OP_FIND,   64'h41);
        send_request(OP_REMOVE, 64'h41);
        send_request(OP_NONE,   64'hFFFF_FFFF_FFFF_FFFF);
        send_request(OP_INSERT, 64'hFFFF_FFFF_FFFF_FFFF);
        send_request(OP_INSERT, 64'h0);
        send_request(OP_INSERT, 64'hA5A5_A5A5_A500_4241);
        send_request(OP_INSERT, 64'h4241);
        send_request(OP_FIND,   64'h5A00_4241);
        send_request(OP_FIND,   64'hFFFF_FF00);
        send_request(OP_FIND,   64'h43);
        send_request(OP_REMOVE, 64'h4241);
        send_request(OP_FIND,   64'h4241);
        send_request(OP_NONE,   64'h0);
        send_request(OP_REMOVE, 64'hFFFF_FFFF_FFFF_FFFF);
        // fill to capacity, then push past it
        while (sb.held < DEPTH)
            send_request(OP_INSERT, dress_name(name_pool[$urandom_range(POOL_SIZE-1)]));
        send_request(OP_INSERT, 64'h4C4C_4146);
        send_request(OP_FIND,   name_pool[0]);
        send_request(OP_REMOVE, name_pool[0]);

        // random: phases that lean toward filling, mixing and draining
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == PAUSE_AT) begin
                s_tvalid <= 1'b0;
                @(posedge aclk);
                while (sb.pending() != 0) @(posedge aclk);
            end
            phase = (n / 150) % 3;
            roll  = $urandom_range(99);
            if (roll < 4)
                op = OP_NONE;
            else if (roll < (phase == 0 ? 65 : (phase == 1 ? 40 : 25)))
                op = OP_INSERT;
            else if (roll < (phase == 2 ? 45 : 72))
                op = OP_FIND;
            else
                op = OP_REMOVE;
            if ($urandom_range(99) < 15)
                key = {$urandom, $urandom};
            else
                key = dress_name(name_pool[$urandom_range(POOL_SIZE-1)]);
            send_request(op, key);
        end
        s_tvalid <= 1'b0;

        while (sb.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("%0d requests: %0d insert, %0d find, %0d remove, %0d undefined op",
                 sent_count, sb.op_count[OP_INSERT], sb.op_count[OP_FIND],
                 sb.op_count[OP_REMOVE], sb.op_count[OP_NONE]);
        $display("%0d results checked, %0d full-table inserts, %0d misses, peak fill %0d",
                 result_count, sb.full_hits, sb.misses, sb.peak_held);
        if (sb.faults == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
